### rtl/lrbc_pkg.sv
// Package for the block read cache tag keeper: constants, item word type
// and state codes. No dependencies.
`timescale 1ns / 1ps
package lrbc_pkg;

  localparam int NUM_SLOTS_DEF = 128;
  localparam int BLOCK_BYTES   = 16384;
  localparam int MAX_PARTS     = 32;
  localparam int LOCAL_W       = $clog2(BLOCK_BYTES);
  localparam int BLK_W         = 32 - LOCAL_W;
  localparam int LEN_W         = LOCAL_W + 1;
  localparam int TAG_W         = 5 + BLK_W + LEN_W;
  localparam int Q_DEPTH       = 2;

  localparam logic [1:0] ST_SERVED   = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FILL_BAD = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  typedef struct packed {
    logic               is_fill;
    logic               part_bad;
    logic               fill_bad;
    logic [4:0]         part;
    logic [BLK_W-1:0]   blk;
    logic [31:0]        base;
    logic [LOCAL_W-1:0] local_off;
    logic [14:0]        req;
    logic [14:0]        fetch;
    logic [LEN_W-1:0]   cnt;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_EXEC = 3'b010,
    BK_WALK = 3'b100
  } bk_state_t;

endpackage

### rtl/lrbc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lrbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/lrbc_front.sv
// Front end: accepts words, classifies them and queues them for the back end.
// Depends on lrbc_pkg.
`timescale 1ns / 1ps
module lrbc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_action,
  input  logic [4:0]    in_part,
  input  logic [31:0]   in_offset,
  input  logic [14:0]   in_req_len,
  input  logic [31:0]   in_part_length,
  input  logic [15:0]   in_fill_count,
  output logic          q_valid,
  output lrbc_pkg::item_t q_item,
  input  logic          q_pop
);
  import lrbc_pkg::*;

  item_t       q_r [Q_DEPTH];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       cls;
  logic        push;
  logic [31:0] rem;

  always_comb begin
    cls.is_fill   = in_action;
    cls.part_bad  = 32'(in_part) >= MAX_PARTS;
    cls.fill_bad  = (in_fill_count == 16'd0) || in_fill_count[15];
    cls.part      = in_part;
    cls.blk       = in_offset[31:LOCAL_W];
    cls.base      = {in_offset[31:LOCAL_W], {LOCAL_W{1'b0}}};
    cls.local_off = in_offset[LOCAL_W-1:0];
    cls.req       = in_req_len;
    rem           = in_part_length - cls.base;
    if (in_part_length > cls.base) begin
      cls.fetch = (rem < 32'(BLOCK_BYTES)) ? rem[14:0] : 15'(BLOCK_BYTES);
    end else begin
      cls.fetch = '0;
    end
    if (in_fill_count > 16'(BLOCK_BYTES)) begin
      cls.cnt = LEN_W'(BLOCK_BYTES);
    end else begin
      cls.cnt = in_fill_count[LEN_W-1:0];
    end
  end

  assign in_stall = (cnt_r == 2'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end
endmodule

### rtl/lrbc_back.sv
// Back end: tag walk, victim choice, fill install, age stamps, result register.
// Depends on lrbc_pkg and lrbc_ram.
`timescale 1ns / 1ps
module lrbc_back #(
  parameter int NUM_SLOTS = lrbc_pkg::NUM_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  lrbc_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output logic [6:0]      out_slot,
  output logic [31:0]     out_block_base,
  output logic [14:0]     out_fetch_len,
  output logic [13:0]     out_blk_offset,
  output logic [14:0]     out_byte_count
);
  import lrbc_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  bk_state_t          state_r, state_nxt;
  item_t              cur_r, cur_nxt;
  logic [NUM_SLOTS-1:0] vld_r, vld_nxt;
  logic [31:0]        age_cnt_r, age_cnt_nxt;
  logic [SLOT_W-1:0]  pend_r, pend_nxt;
  logic [SLOT_W:0]    issue_r, issue_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [SLOT_W-1:0]  vic_r, vic_nxt;
  logic [31:0]        vic_age_r, vic_age_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [6:0]         slot_r, slot_nxt;
  logic [31:0]        base_r, base_nxt;
  logic [14:0]        fetch_r, fetch_nxt;
  logic [13:0]        local_r, local_nxt;
  logic [14:0]        count_r, count_nxt;

  logic               tag_we, age_we;
  logic [SLOT_W-1:0]  tag_waddr, age_waddr, rd_addr;
  logic [TAG_W-1:0]   tag_wdata, tag_rd;
  logic [31:0]        age_rd, age_eff;
  logic [4:0]         rd_part;
  logic [BLK_W-1:0]   rd_blk;
  logic [LEN_W-1:0]   rd_len, srv_len, avail;
  logic [SLOT_W-1:0]  srv_slot;
  logic               do_serve;

  lrbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SLOTS)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(rd_addr), .rdata(tag_rd)
  );

  lrbc_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_age (
    .clk(clk), .we(age_we), .waddr(age_waddr), .wdata(age_cnt_nxt),
    .raddr(rd_addr), .rdata(age_rd)
  );

  assign {rd_part, rd_blk, rd_len} = tag_rd;
  assign age_eff   = vld_r[cmp_idx_r] ? age_rd : 32'd0;
  assign tag_waddr = pend_r;
  assign tag_wdata = {cur_r.part, cur_r.blk, cur_r.cnt};
  assign age_waddr = srv_slot;
  assign avail     = srv_len - LEN_W'(cur_r.local_off);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    vld_nxt       = vld_r;
    age_cnt_nxt   = age_cnt_r;
    pend_nxt      = pend_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    vic_nxt       = vic_r;
    vic_age_nxt   = vic_age_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    fetch_nxt     = fetch_r;
    local_nxt     = local_r;
    count_nxt     = count_r;
    q_pop         = 1'b0;
    tag_we        = 1'b0;
    age_we        = 1'b0;
    rd_addr       = issue_r[SLOT_W-1:0];
    do_serve      = 1'b0;
    srv_slot      = cmp_idx_r;
    srv_len       = rd_len;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        base_nxt  = cur_r.base;
        local_nxt = 14'(cur_r.local_off);
        fetch_nxt = '0;
        count_nxt = '0;
        if (cur_r.is_fill) begin
          slot_nxt  = 7'(32'(pend_r));
          state_nxt = BK_IDLE;
          if (cur_r.part_bad || cur_r.fill_bad) begin
            status_nxt    = ST_FILL_BAD;
            out_valid_nxt = 1'b1;
          end else begin
            tag_we           = 1'b1;
            vld_nxt[pend_r]  = 1'b1;
            srv_slot         = pend_r;
            srv_len          = cur_r.cnt;
            do_serve         = 1'b1;
          end
        end else if (cur_r.part_bad) begin
          status_nxt    = ST_PAST_END;
          slot_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end else begin
          rd_addr     = '0;
          issue_nxt   = (SLOT_W+1)'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = '0;
          state_nxt   = BK_WALK;
        end
      end
      BK_WALK: begin
        if (issue_r < (SLOT_W+1)'(NUM_SLOTS)) begin
          issue_nxt   = issue_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[SLOT_W-1:0];
        end
        if (cmp_vld_r) begin
          if (vld_r[cmp_idx_r] && rd_part == cur_r.part && rd_blk == cur_r.blk) begin
            slot_nxt    = 7'(32'(cmp_idx_r));
            do_serve    = 1'b1;
            cmp_vld_nxt = 1'b0;
            state_nxt   = BK_IDLE;
          end else begin
            if (cmp_idx_r == '0 || !vld_r[cmp_idx_r] || age_eff < vic_age_r) begin
              vic_nxt     = cmp_idx_r;
              vic_age_nxt = age_eff;
            end
            if (cmp_idx_r == SLOT_W'(NUM_SLOTS - 1)) begin
              pend_nxt      = vic_nxt;
              status_nxt    = ST_MISS;
              slot_nxt      = 7'(32'(vic_nxt));
              fetch_nxt     = cur_r.fetch;
              out_valid_nxt = 1'b1;
              cmp_vld_nxt   = 1'b0;
              state_nxt     = BK_IDLE;
            end
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (do_serve) begin
      age_cnt_nxt   = age_cnt_r + 32'd1;
      age_we        = 1'b1;
      out_valid_nxt = 1'b1;
      if (LEN_W'(cur_r.local_off) >= srv_len) begin
        status_nxt = ST_PAST_END;
        count_nxt  = '0;
      end else begin
        status_nxt = ST_SERVED;
        count_nxt  = (LEN_W'(cur_r.req) < avail) ? cur_r.req : 15'(avail);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      vld_r       <= '0;
      age_cnt_r   <= '0;
      pend_r      <= '0;
      issue_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      age_cnt_r   <= age_cnt_nxt;
      pend_r      <= pend_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    vic_r     <= vic_nxt;
    vic_age_r <= vic_age_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    base_r    <= base_nxt;
    fetch_r   <= fetch_nxt;
    local_r   <= local_nxt;
    count_r   <= count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_slot         = slot_r;
  assign out_block_base   = base_r;
  assign out_fetch_len    = fetch_r;
  assign out_blk_offset   = local_r;
  assign out_byte_count   = count_r;

  a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !out_valid_r)
    else $error("back end busy while result register occupied");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE))
    else $error("queue popped outside idle");
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    tag_we |=> (state_r == BK_IDLE) && out_valid_r)
    else $error("fill install did not produce a result");
  a_walk_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) |-> cmp_vld_r)
    else $error("tag walk lost its compare slot");
endmodule

### rtl/lru_block_read_cache.sv
// Top level of the block read cache tag keeper: front end, queue, back end.
// Depends on lrbc_pkg, lrbc_front, lrbc_back, lrbc_ram.
//
// Input channel (in_*): one word is either a lookup (in_action 0) or a fill
// report for the pending miss (in_action 1). Taken when in_valid is high and
// in_stall is low. A two-word queue sits behind the input.
// Result channel (out_*): one result word per input word, in order, held in
// an output register until out_valid is high and out_stall is low.
// Lookup miss: the result is set by the tag walk, which reads one slot per
// cycle from the tag and age memories and, on a miss, visits every slot;
// a hit on slot i ends the walk at that slot.
// Fill report or out-of-range part: no tag walk; the exec state sets the result.
// One word is worked on at a time; a new word starts once the result
// register is free.
// Reset (rst_n low, synchronous) clears all slot valid bits, the age counter
// and the pending slot; no clearing pass is needed.
// A stalled receiver holds the result; the queue keeps taking words until
// it holds two, then in_stall rises.
`timescale 1ns / 1ps
module lru_block_read_cache #(
  parameter int NUM_SLOTS = lrbc_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [4:0]  in_part,
  input  logic [31:0] in_offset,
  input  logic [14:0] in_req_len,
  input  logic [31:0] in_part_length,
  input  logic [15:0] in_fill_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_slot,
  output logic [31:0] out_block_base,
  output logic [14:0] out_fetch_len,
  output logic [13:0] out_blk_offset,
  output logic [14:0] out_byte_count
);
  import lrbc_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  lrbc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_part(in_part), .in_offset(in_offset), .in_req_len(in_req_len),
    .in_part_length(in_part_length), .in_fill_count(in_fill_count),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  lrbc_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_slot(out_slot), .out_block_base(out_block_base),
    .out_fetch_len(out_fetch_len), .out_blk_offset(out_blk_offset),
    .out_byte_count(out_byte_count)
  );
endmodule

### bench/lru_block_read_cache_tb.sv
// Testbench for lru_block_read_cache: directed and random lookups and fill
// reports, checked against a behavioral tag and age keeper. Depends on lrbc_pkg.
`timescale 1ns / 1ps
module lru_block_read_cache_tb;
  import lrbc_pkg::*;

  localparam int SLOTS = 128;

  typedef struct {
    logic [1:0]  status;
    logic [6:0]  slot;
    logic [31:0] base;
    logic [14:0] fetch;
    logic [13:0] local_off;
    logic [14:0] count;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [4:0]  in_part = '0;
  logic [31:0] in_offset = '0;
  logic [14:0] in_req_len = '0;
  logic [31:0] in_part_length = '0;
  logic [15:0] in_fill_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [6:0]  out_slot;
  logic [31:0] out_block_base;
  logic [14:0] out_fetch_len;
  logic [13:0] out_blk_offset;
  logic [14:0] out_byte_count;

  lru_block_read_cache u_dut (.*);

  always #5 clk = ~clk;

  // tag and age model
  logic        tag_valid [SLOTS];
  logic [4:0]  tag_part [SLOTS];
  logic [17:0] tag_blk [SLOTS];
  logic [14:0] tag_len [SLOTS];
  logic [31:0] tag_age [SLOTS];
  logic [31:0] age_clock;
  logic [6:0]  pending_victim;

  answer_t answers_due[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic answer_t stamp_and_serve(int s, logic [31:0] base, logic [13:0] loc,
                                              logic [14:0] req);
    answer_t a;
    age_clock = age_clock + 1;
    tag_age[s] = age_clock;
    a.slot = s[6:0];
    a.base = base;
    a.fetch = '0;
    a.local_off = loc;
    if ({1'b0, loc} >= tag_len[s]) begin
      a.status = ST_PAST_END;
      a.count = '0;
    end else begin
      a.status = ST_SERVED;
      a.count = (req < tag_len[s] - loc) ? req : tag_len[s] - loc;
    end
    return a;
  endfunction

  function automatic answer_t predict_answer(logic act, logic [4:0] part, logic [31:0] off,
                                             logic [14:0] req, logic [31:0] plen,
                                             logic [15:0] fill);
    answer_t a;
    logic [17:0] blk;
    logic [31:0] base;
    logic [13:0] loc;
    int victim;
    logic [31:0] rem;
    blk = off[31:14];
    base = {blk, 14'd0};
    loc = off[13:0];
    if (act) begin
      if (fill == 16'd0 || fill[15]) begin
        a = '{ST_FILL_BAD, pending_victim, base, 15'd0, loc, 15'd0};
        return a;
      end
      tag_valid[pending_victim] = 1'b1;
      tag_part[pending_victim] = part;
      tag_blk[pending_victim] = blk;
      tag_len[pending_victim] = (fill > BLOCK_BYTES) ? 15'(BLOCK_BYTES) : fill[14:0];
      return stamp_and_serve(pending_victim, base, loc, req);
    end
    victim = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_valid[i] && tag_part[i] == part && tag_blk[i] == blk)
        return stamp_and_serve(i, base, loc, req);
      if (!tag_valid[i] || tag_age[i] < tag_age[victim]) victim = i;
    end
    rem = plen - base;
    a.fetch = (plen <= base) ? 15'd0 : (rem < BLOCK_BYTES) ? rem[14:0] : 15'(BLOCK_BYTES);
    pending_victim = victim[6:0];
    a.status = ST_MISS;
    a.slot = victim[6:0];
    a.base = base;
    a.local_off = loc;
    a.count = '0;
    return a;
  endfunction

  // returns the predicted status of the accepted word
  task automatic send_word(input logic act, input logic [4:0] part, input logic [31:0] off,
                           input logic [14:0] req, input logic [31:0] plen,
                           input logic [15:0] fill, output logic [1:0] st);
    answer_t a;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_part <= part;
    in_offset <= off;
    in_req_len <= req;
    in_part_length <= plen;
    in_fill_count <= fill;
    do @(posedge clk); while (in_stall);
    a = predict_answer(act, part, off, req, plen, fill);
    answers_due.push_back(a);
    st = a.status;
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS_DEF + 10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $display("%0t unexpected word: status %0d slot %0d", $time, out_status, out_slot);
        errors++;
      end else begin
        e = answers_due.pop_front();
        if (out_status !== e.status) begin
          $display("%0t status exp %0d got %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_slot !== e.slot) begin
          $display("%0t slot exp %0d got %0d", $time, e.slot, out_slot);
          errors++;
        end
        if (out_block_base !== e.base) begin
          $display("%0t block_base exp %h got %h", $time, e.base, out_block_base);
          errors++;
        end
        if (out_fetch_len !== e.fetch) begin
          $display("%0t fetch_len exp %0d got %0d", $time, e.fetch, out_fetch_len);
          errors++;
        end
        if (out_blk_offset !== e.local_off) begin
          $display("%0t blk_offset exp %0d got %0d", $time, e.local_off, out_blk_offset);
          errors++;
        end
        if (out_byte_count !== e.count) begin
          $display("%0t byte_count exp %0d got %0d", $time, e.count, out_byte_count);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [1:0] st;
    send_word(1'b0, 5'd0, 32'd100, 15'd50, 32'd100000, 16'd0, st);      // miss on empty cache
    send_word(1'b1, 5'd0, 32'd100, 15'd50, 32'd0, 16'hFFFF, st);         // failed fill
    send_word(1'b1, 5'd0, 32'd100, 15'd50, 32'd0, 16'd0, st);            // zero fill
    send_word(1'b1, 5'd0, 32'd100, 15'd50, 32'd0, 16'd16384, st);        // full block
    send_word(1'b0, 5'd0, 32'd16383, 15'h7FFF, 32'd0, 16'd0, st);        // hit at block end
    send_word(1'b0, 5'd0, 32'd0, 15'd0, 32'd0, 16'd0, st);               // hit, zero request
    send_word(1'b0, 5'd31, 32'hFFFFFFFF, 15'd10, 32'hFFFFFFFF, 16'd0, st);
    send_word(1'b1, 5'd31, 32'hFFFFFFFF, 15'd10, 32'd0, 16'h7FFF, st);   // clamped fill
    send_word(1'b0, 5'd31, 32'hFFFFC000, 15'd16384, 32'd0, 16'd0, st);
    send_word(1'b0, 5'd1, 32'd40000, 15'd5, 32'd30000, 16'd0, st);       // part ends before block
    send_word(1'b1, 5'd1, 32'd40000, 15'd5, 32'd0, 16'd100, st);         // short block, past end
    send_word(1'b0, 5'd1, 32'd32768 + 99, 15'd5, 32'd0, 16'd0, st);
    send_word(1'b0, 5'd1, 32'd32768 + 98, 15'd5, 32'd0, 16'd0, st);
    send_word(1'b0, 5'd2, 32'd16384, 15'd1, 32'd20000, 16'd0, st);       // partial fetch
    send_word(1'b1, 5'd3, 32'd70000, 15'd1, 32'd0, 16'd16385, st);       // fill tagged differently
    send_word(1'b1, 5'd4, 32'd5, 15'd3, 32'd0, 16'd1, st);               // fill, no miss pending
    send_word(1'b0, 5'd3, 32'd65536, 15'd3, 32'd0, 16'd0, st);
    send_word(1'b1, 5'd0, 32'd0, 15'd0, 32'd0, 16'h8000, st);
    drain_answers();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    logic [1:0] st;
    logic [4:0] part;
    logic [31:0] off, plen;
    logic [15:0] fill;
    int sent;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) != 0) begin
        part = $urandom_range(3);
        off = {$urandom_range(1) ? 18'($urandom_range(63)) : 18'($urandom), 14'($urandom)};
        case ($urandom_range(2))
          0: plen = $urandom;
          1: plen = {off[31:14], 14'd0} + $urandom_range(20000);
          default: plen = 32'hFFFFFFFF;
        endcase
        send_word(1'b0, part, off, 15'($urandom_range(16384)), plen, 16'($urandom), st);
        sent++;
        if (st == ST_MISS) begin
          case ($urandom_range(5))
            0: fill = 16'($urandom);
            1: fill = 16'($urandom_range(20000));
            default: fill = 16'($urandom_range(16384, 1));
          endcase
          send_word(1'b1, part, off, 15'($urandom), 32'($urandom), fill, st);
          sent++;
        end
      end else begin
        send_word(1'($urandom), 5'($urandom), $urandom, 15'($urandom), $urandom,
                  16'($urandom), st);
        sent++;
      end
      if (sent % 40 == 39 && $urandom_range(1) != 0) drain_answers();
    end
    drain_answers();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_age[i] = '0;
    end
    age_clock = '0;
    pending_victim = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(110, 0, 0);
    test_random(110, 54, 0);
    test_random(110, 0, 54);
    test_random(120, 18, 18);
    if (answers_due.size() != 0) begin
      $display("%0t %0d expected words never arrived", $time, answers_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/lrbc_pkg.sv
rtl/lrbc_ram.sv
rtl/lrbc_front.sv
rtl/lrbc_back.sv
rtl/lru_block_read_cache.sv
bench/lru_block_read_cache_tb.sv
